FILE: rtl/core/qcspq_pkg.sv
// Shared constants and types of the strict priority packet queue.
`timescale 1ns / 1ps
`default_nettype none
package qcspq_pkg;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 64;
   localparam int HANDLE_BITS = 16;

   localparam int QIDX_W = $clog2(NUM_QUEUES);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   localparam logic [15:0] TYPE_LABELLED = 16'h0601;
   localparam logic [15:0] TYPE_DISCARD  = 16'h0600;
   localparam logic [7:0]  LABEL_CLASSES = 8'd8;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_PULL = 1'b1;
   localparam logic PORT_QUERY = 1'b0;

   typedef struct packed {
      logic              found;
      logic [QIDX_W-1:0] idx;
   } pick_type;

endpackage
`default_nettype wire

FILE: rtl/core/qcspq_pick.sv
// Strict priority selection: lowest-numbered queue that holds a word.
`timescale 1ns / 1ps
`default_nettype none
module qcspq_pick (
   input  wire logic [qcspq_pkg::NUM_QUEUES-1:0] nonempty,
   output qcspq_pkg::pick_type                   pick
);

   always_comb begin
      pick.found = 1'b0;
      pick.idx   = '0;
      for (int i = qcspq_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            pick.found = 1'b1;
            pick.idx   = qcspq_pkg::QIDX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/qos_classify_strict_priority_queue_core.sv
// Top level of the strict priority packet queue: classification, pointers and handle store.
`timescale 1ns / 1ps
`default_nettype none
// One request word is either a push of a packet handle or a pull. A push is
// classified, written into its queue and answered in the next cycle. A pull picks the
// lowest-numbered non-empty queue and reads its head from the synchronous handle store
// into a read register, which the read state then moves to the response register; an
// empty pull is answered in the next cycle. One request is in work at a time: the block
// takes a new word when no pull read is pending and the response register is empty or
// being drained in the same cycle. Pointers and fill counts are cleared by reset; the
// handle store needs no clearing pass.
module qos_classify_strict_priority_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic        req_in_port,
   input  wire logic [15:0] req_frame_type,
   input  wire logic [7:0]  req_qos_label,
   input  wire logic [15:0] req_packet_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_done_res,
   output logic             rsp_dropped,
   output logic [2:0]       rsp_queue_used,
   output logic [15:0]      rsp_packet_out
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;

   logic [qcspq_pkg::PTR_W-1:0] head_ff [qcspq_pkg::NUM_QUEUES];
   logic [qcspq_pkg::PTR_W-1:0] tail_ff [qcspq_pkg::NUM_QUEUES];
   logic [qcspq_pkg::CNT_W-1:0] count_ff [qcspq_pkg::NUM_QUEUES];

   logic [qcspq_pkg::HANDLE_BITS-1:0] store_mem [qcspq_pkg::NUM_QUEUES * qcspq_pkg::QUEUE_DEPTH];
   logic [qcspq_pkg::HANDLE_BITS-1:0] rd_data_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         rsp_drop_ff, rsp_drop_in;
   logic [2:0]                   rsp_queue_ff, rsp_queue_in;
   logic [15:0]                  rsp_packet_ff, rsp_packet_in;
   logic [qcspq_pkg::QIDX_W-1:0] pull_q_ff, pull_q_in;

   logic [qcspq_pkg::NUM_QUEUES-1:0] nonempty;
   qcspq_pkg::pick_type              pick;

   logic                         req_fire;
   logic                         push_fire;
   logic                         pull_fire;
   logic [7:0]                   label_m1;
   logic                         push_accept;
   logic [qcspq_pkg::QIDX_W-1:0] push_q;
   logic                         push_full;
   logic                         push_store;
   logic [qcspq_pkg::ADDR_W-1:0] wr_addr;
   logic [qcspq_pkg::ADDR_W-1:0] rd_addr;

   always_comb begin
      for (int i = 0; i < qcspq_pkg::NUM_QUEUES; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   qcspq_pick u_pick (
      .nonempty (nonempty),
      .pick     (pick)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign push_fire = req_fire && (req_kind == qcspq_pkg::KIND_PUSH);
   assign pull_fire = req_fire && (req_kind == qcspq_pkg::KIND_PULL);

   // Port 1, untyped: queue 0; labelled: queue label-1; discard or bad label: dropped.
   assign label_m1 = req_qos_label - 8'd1;
   always_comb begin
      push_accept = 1'b1;
      push_q      = '0;
      if (req_in_port == qcspq_pkg::PORT_QUERY) begin
         if (req_frame_type == qcspq_pkg::TYPE_LABELLED) begin
            if ((req_qos_label != 8'd0) && (req_qos_label <= qcspq_pkg::LABEL_CLASSES) &&
                (label_m1 < 8'(qcspq_pkg::NUM_QUEUES))) begin
               push_q = label_m1[qcspq_pkg::QIDX_W-1:0];
            end else begin
               push_accept = 1'b0;
            end
         end else if (req_frame_type == qcspq_pkg::TYPE_DISCARD) begin
            push_accept = 1'b0;
         end
      end
   end

   assign push_full  = (count_ff[push_q] == qcspq_pkg::CNT_W'(qcspq_pkg::QUEUE_DEPTH));
   assign push_store = push_fire && push_accept && !push_full;

   assign wr_addr = qcspq_pkg::ADDR_W'(push_q) * qcspq_pkg::ADDR_W'(qcspq_pkg::QUEUE_DEPTH)
                    + qcspq_pkg::ADDR_W'(tail_ff[push_q]);
   assign rd_addr = qcspq_pkg::ADDR_W'(pick.idx) * qcspq_pkg::ADDR_W'(qcspq_pkg::QUEUE_DEPTH)
                    + qcspq_pkg::ADDR_W'(head_ff[pick.idx]);

   always_ff @(posedge clock) begin
      if (push_store) begin
         store_mem[wr_addr] <= req_packet_in[qcspq_pkg::HANDLE_BITS-1:0];
      end
      if (pull_fire) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qcspq_pkg::NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (push_store) begin
            tail_ff[push_q]  <= (tail_ff[push_q] == qcspq_pkg::PTR_W'(qcspq_pkg::QUEUE_DEPTH - 1))
                                ? '0 : tail_ff[push_q] + 1'b1;
            count_ff[push_q] <= count_ff[push_q] + 1'b1;
         end
         if (pull_fire && pick.found) begin
            head_ff[pick.idx]  <= (head_ff[pick.idx] ==
                                   qcspq_pkg::PTR_W'(qcspq_pkg::QUEUE_DEPTH - 1))
                                  ? '0 : head_ff[pick.idx] + 1'b1;
            count_ff[pick.idx] <= count_ff[pick.idx] - 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pull_q_in     = pull_q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_done_in   = rsp_done_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_queue_in  = rsp_queue_ff;
      rsp_packet_in = rsp_packet_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (push_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_done_in   = push_store;
               rsp_drop_in   = !push_store;
               rsp_queue_in  = push_accept ? 3'(push_q) : 3'd0;
               rsp_packet_in = '0;
            end else if (pull_fire) begin
               if (pick.found) begin
                  state_in  = ST_READ;
                  pull_q_in = pick.idx;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_done_in   = 1'b0;
                  rsp_drop_in   = 1'b0;
                  rsp_queue_in  = 3'd0;
                  rsp_packet_in = '0;
               end
            end
         end
         ST_READ: begin
            // The response register was drained before the pull was taken.
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_done_in   = 1'b1;
            rsp_drop_in   = 1'b0;
            rsp_queue_in  = 3'(pull_q_ff);
            rsp_packet_in = 16'(rd_data_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pull_q_ff     <= pull_q_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_queue_ff  <= rsp_queue_in;
      rsp_packet_ff <= rsp_packet_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_queue_used = rsp_queue_ff;
   assign rsp_packet_out = rsp_packet_ff;

   a_read_output_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("pull read pending while a response word is still held");

   a_pull_goes_read: assert property (@(posedge clock) disable iff (reset)
      (pull_fire && pick.found) |=> (state_ff == ST_READ))
      else $error("pull of a non-empty queue did not start a store read");

   a_pick_nonempty: assert property (@(posedge clock) disable iff (reset)
      pick.found |-> (count_ff[pick.idx] != '0))
      else $error("selected queue is empty");

   a_done_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_drop_ff))
      else $error("response word marked both queued and dropped");

endmodule
`default_nettype wire

FILE: tb/qos_classify_strict_priority_queue_core_tb.sv
// Testbench of the strict priority packet queue: predicted responses checked word by word.
`timescale 1ns / 1ps
module qos_classify_strict_priority_queue_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 8;
   localparam logic [31:0] HANDLE_MASK =
      (qcspq_pkg::HANDLE_BITS >= 32) ? 32'hFFFF_FFFF
                                     : (32'd1 << qcspq_pkg::HANDLE_BITS) - 32'd1;

   typedef struct packed {
      logic        kind;
      logic        in_port;
      logic [15:0] frame_type;
      logic [7:0]  qos_label;
      logic [15:0] packet_in;
   } req_word_type;

   typedef struct packed {
      logic        done_res;
      logic        dropped;
      logic [2:0]  queue_used;
      logic [15:0] packet_out;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_kind = qcspq_pkg::KIND_PUSH;
   logic        req_in_port = qcspq_pkg::PORT_QUERY;
   logic [15:0] req_frame_type = '0;
   logic [7:0]  req_qos_label = '0;
   logic [15:0] req_packet_in = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_done_res;
   logic        rsp_dropped;
   logic [2:0]  rsp_queue_used;
   logic [15:0] rsp_packet_out;

   qos_classify_strict_priority_queue_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_in_port    (req_in_port),
      .req_frame_type (req_frame_type),
      .req_qos_label  (req_qos_label),
      .req_packet_in  (req_packet_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_done_res   (rsp_done_res),
      .rsp_dropped    (rsp_dropped),
      .rsp_queue_used (rsp_queue_used),
      .rsp_packet_out (rsp_packet_out)
   );

   // Shadow copy of the queues, kept in step with every accepted request word.
   logic [15:0] handle_store [qcspq_pkg::NUM_QUEUES][qcspq_pkg::QUEUE_DEPTH];
   int unsigned head_idx [qcspq_pkg::NUM_QUEUES] = '{default: 0};
   int unsigned tail_idx [qcspq_pkg::NUM_QUEUES] = '{default: 0};
   int unsigned fill_cnt [qcspq_pkg::NUM_QUEUES] = '{default: 0};

   rsp_word_type expected_rsps [$];
   int errors = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_word_type classify_and_serve(input req_word_type w);
      rsp_word_type r;
      int unsigned  q;
      logic         accept;
      logic         found;
      logic [15:0]  handle;
      r = '0;
      q = 0;
      accept = 1'b1;
      found = 1'b0;
      handle = w.packet_in & HANDLE_MASK[15:0];
      if (w.kind == qcspq_pkg::KIND_PUSH) begin
         if (w.in_port == qcspq_pkg::PORT_QUERY) begin
            if (w.frame_type == qcspq_pkg::TYPE_LABELLED) begin
               if (w.qos_label >= 8'd1 && w.qos_label <= qcspq_pkg::LABEL_CLASSES &&
                   int'(w.qos_label) - 1 < qcspq_pkg::NUM_QUEUES) begin
                  q = int'(w.qos_label) - 1;
               end else begin
                  accept = 1'b0;
               end
            end else if (w.frame_type == qcspq_pkg::TYPE_DISCARD) begin
               accept = 1'b0;
            end
         end
         if (!accept) begin
            r.dropped = 1'b1;
         end else if (fill_cnt[q] >= qcspq_pkg::QUEUE_DEPTH) begin
            r.dropped = 1'b1;
            r.queue_used = 3'(q);
         end else begin
            handle_store[q][tail_idx[q]] = handle;
            tail_idx[q] = (tail_idx[q] + 1 >= qcspq_pkg::QUEUE_DEPTH)
                          ? 0 : tail_idx[q] + 1;
            fill_cnt[q]++;
            r.done_res = 1'b1;
            r.queue_used = 3'(q);
         end
      end else begin
         for (int i = 0; i < qcspq_pkg::NUM_QUEUES; i++) begin
            if (!found && fill_cnt[i] != 0) begin
               r.packet_out = handle_store[i][head_idx[i]];
               head_idx[i] = (head_idx[i] + 1 >= qcspq_pkg::QUEUE_DEPTH)
                             ? 0 : head_idx[i] + 1;
               fill_cnt[i]--;
               r.done_res = 1'b1;
               r.queue_used = 3'(i);
               found = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Valid is left high on return so that a following word goes out back to back.
   task automatic send_word(input req_word_type w);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_in_port <= w.in_port;
      req_frame_type <= w.frame_type;
      req_qos_label <= w.qos_label;
      req_packet_in <= w.packet_in;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(classify_and_serve(w));
   endtask

   task automatic push_word(input logic port, input logic [15:0] etype,
                            input logic [7:0] label, input logic [15:0] handle);
      send_word('{qcspq_pkg::KIND_PUSH, port, etype, label, handle});
   endtask

   // Fields other than the kind mean nothing to a pull, so they are random.
   task automatic pull_word();
      send_word('{qcspq_pkg::KIND_PULL, 1'($urandom), 16'($urandom), 8'($urandom),
                  16'($urandom)});
   endtask

   // The loop waits on the clock before it checks the queue, so valid is never lowered and raised in one step.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   function automatic req_word_type random_word(input int push_pct);
      req_word_type w;
      int           pick;
      w.kind = ($urandom_range(0, 99) < push_pct) ? qcspq_pkg::KIND_PUSH
                                                  : qcspq_pkg::KIND_PULL;
      w.in_port = ($urandom_range(0, 3) == 0) ? ~qcspq_pkg::PORT_QUERY
                                              : qcspq_pkg::PORT_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         w.frame_type = qcspq_pkg::TYPE_LABELLED;
      end else if (pick < 65) begin
         w.frame_type = qcspq_pkg::TYPE_DISCARD;
      end else if (pick < 72) begin
         // One bit away from the labelled type.
         w.frame_type = qcspq_pkg::TYPE_LABELLED ^ (16'd1 << $urandom_range(0, 15));
      end else begin
         w.frame_type = 16'($urandom);
      end
      w.qos_label = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 8)) : 8'($urandom);
      w.packet_in = 16'($urandom);
      return w;
   endfunction

   task automatic random_phase(input int count, input int push_pct);
      repeat (count) send_word(random_word(push_pct));
   endtask

   task automatic test_directed();
      send_gap_pct = 20;
      stall_pct = 20;
      pull_word();
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd1, 16'hFFFF);
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd8, 16'h0000);
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd0, 16'h1111);
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd9, 16'h2222);
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'hFF, 16'h3333);
      push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_DISCARD, 8'd3, 16'h4444);
      push_word(~qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_DISCARD, 8'd0, 16'h5555);
      push_word(~qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd5, 16'h6666);
      push_word(qcspq_pkg::PORT_QUERY, 16'hFFFF, 8'hFF, 16'h7777);
      push_word(qcspq_pkg::PORT_QUERY, 16'h0000, 8'h00, 16'h8888);
      push_word(qcspq_pkg::PORT_QUERY, 16'h0602, 8'd2, 16'h9999);
      for (int label = 2; label <= 7; label++) begin
         push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'(label),
                   16'(16'hA000 + label));
      end
      repeat (13) pull_word();
      drain_responses();
   endtask

   // Queues 0, 3 and 7 are pushed past their depth, then everything is pulled out.
   task automatic test_full_queues();
      send_gap_pct = 10;
      stall_pct = 30;
      repeat (qcspq_pkg::QUEUE_DEPTH + 3) begin
         push_word(~qcspq_pkg::PORT_QUERY, 16'($urandom), 8'($urandom), 16'($urandom));
      end
      repeat (qcspq_pkg::QUEUE_DEPTH + 3) begin
         push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd4, 16'($urandom));
      end
      repeat (qcspq_pkg::QUEUE_DEPTH + 3) begin
         push_word(qcspq_pkg::PORT_QUERY, qcspq_pkg::TYPE_LABELLED, 8'd8, 16'($urandom));
      end
      repeat (3 * qcspq_pkg::QUEUE_DEPTH + 4) pull_word();
      drain_responses();
   endtask

   task automatic test_random_mix();
      send_gap_pct = 25;
      stall_pct = 25;
      random_phase(500, 50);
      drain_responses();
   endtask

   task automatic test_fill_and_drain();
      send_gap_pct = 0;
      stall_pct = 40;
      random_phase(250, 85);
      send_gap_pct = 30;
      stall_pct = 0;
      random_phase(250, 15);
      drain_responses();
   endtask

   task automatic test_no_idle();
      send_gap_pct = 0;
      stall_pct = 0;
      random_phase(250, 55);
      drain_responses();
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response word arrived with none expected");
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_done_res !== want.done_res) begin
               $error("done_res: expected %0d, got %0d", want.done_res, rsp_done_res);
               errors++;
            end
            if (rsp_dropped !== want.dropped) begin
               $error("dropped: expected %0d, got %0d", want.dropped, rsp_dropped);
               errors++;
            end
            if (rsp_queue_used !== want.queue_used) begin
               $error("queue_used: expected %0d, got %0d", want.queue_used, rsp_queue_used);
               errors++;
            end
            if (rsp_packet_out !== want.packet_out) begin
               $error("packet_out: expected %h, got %h", want.packet_out, rsp_packet_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_queues();
      test_random_mix();
      test_fill_and_drain();
      test_no_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
